// File: rtl/frms_pkg.sv
package frms_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 12;

    // default frame length limit
    localparam int MAX_SAMPLES_DEF = 4096;

    // square of a full-scale sample is 2^30, so 31 bits hold any square
    localparam int SQUARE_LOG2 = 2 * (SAMPLE_W - 1);
    localparam int SQUARE_W    = SQUARE_LOG2 + 1;

    // bit-serial multiplier operand width and step counter width
    localparam int MUL_W  = 31;
    localparam int STEP_W = $clog2(MUL_W + 1);

    // log2 arithmetic: mantissa in Q1.30, 16 fraction bits of result
    localparam int MANT_FRAC = 30;
    localparam int LG_FRAC   = 16;
    localparam int RND_W     = $clog2(LG_FRAC + 1);

    // full scale is 2^30 in the mean square domain
    localparam int FULL_SCALE_LOG2 = 30;

    // 100*log10(2) in Q16, tenths of a dB per unit of log2
    localparam int TENTHS_PER_LOG2_Q16 = 1972830;

    // final product is rounded at this bit position
    localparam int ROUND_SHIFT = 32;

    // floor level after reset
    localparam logic signed [LEVEL_W-1:0] FLOOR_RESET = -12'sd1000;

    // start request to the serial multiplier
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } mul_ctl_t;

endpackage

// File: rtl/frms_serial_mul.sv
module frms_serial_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  frms_pkg::mul_ctl_t            ctl,
    input  logic [frms_pkg::MUL_W-1:0]    a,
    input  logic [frms_pkg::MUL_W-1:0]    b,
    output logic [2*frms_pkg::MUL_W-1:0]  product,
    output logic                          done
);

    localparam int W = frms_pkg::MUL_W;

    logic [W-1:0]                  a_reg, a_next;
    logic [W-1:0]                  hi_reg, hi_next;
    logic [W-1:0]                  lo_reg, lo_next;
    logic [frms_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [W:0]                    add_sum;

    // one multiplier bit per cycle, lsb first, partial sum shifts right
    assign add_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(W+1){1'b0}});

    always_comb begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = ctl.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = add_sum[W:1];
            lo_next  = {add_sum[0], lo_reg[W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == frms_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial product shift registers
    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign product = {hi_reg, lo_reg};
    assign done    = done_reg;

endmodule

// File: rtl/frms_log2.sv
module frms_log2 #(
    parameter int LW = 43
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic [LW-1:0]                             x,
    output logic [$clog2(LW)+frms_pkg::LG_FRAC-1:0]   lg,
    output logic                                      done
);

    localparam int W     = frms_pkg::MUL_W;
    localparam int EXP_W = $clog2(LW);
    localparam int SQR_W = 2 * W - frms_pkg::MANT_FRAC;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQ   = 3'b100
    } lg_state_t;

    lg_state_t                       state_reg, state_next;
    logic [LW-1:0]                   norm_reg, norm_next;
    logic [EXP_W-1:0]                exp_reg, exp_next;
    logic [frms_pkg::LG_FRAC-1:0]    frac_reg, frac_next;
    logic [frms_pkg::RND_W-1:0]      round_reg, round_next;
    logic                            done_reg, done_next;

    frms_pkg::mul_ctl_t              mul_ctl;
    logic [W-1:0]                    mul_op;
    logic [2*W-1:0]                  mul_prod;
    logic                            mul_done;
    logic [SQR_W-1:0]                sq;
    logic [W-1:0]                    next_m;

    frms_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a       (mul_op),
        .b       (mul_op),
        .product (mul_prod),
        .done    (mul_done)
    );

    // square shifted back to Q1.30; renormalise when it reaches 2.0
    assign sq     = mul_prod[2*W-1:frms_pkg::MANT_FRAC];
    assign next_m = sq[SQR_W-1] ? sq[SQR_W-1:1] : sq[SQR_W-2:0];

    always_comb begin
        state_next    = state_reg;
        norm_next     = norm_reg;
        exp_next      = exp_reg;
        frac_next     = frac_reg;
        round_next    = round_reg;
        done_next     = 1'b0;
        mul_ctl.start = 1'b0;
        mul_ctl.steps = frms_pkg::STEP_W'(W);
        mul_op        = norm_reg[LW-1 -: W];
        unique case (state_reg)
            L_IDLE: begin
                if (start) begin
                    norm_next  = x;
                    exp_next   = EXP_W'(LW - 1);
                    frac_next  = '0;
                    state_next = L_NORM;
                end
            end
            // shift left one bit a cycle until the top bit is set or the exponent is zero
            L_NORM: begin
                if (norm_reg[LW-1] || exp_reg == '0) begin
                    mul_ctl.start = 1'b1;
                    round_next    = frms_pkg::RND_W'(frms_pkg::LG_FRAC);
                    state_next    = L_SQ;
                end else begin
                    norm_next = {norm_reg[LW-2:0], 1'b0};
                    exp_next  = exp_reg - 1'b1;
                end
            end
            // one fraction bit per squaring round
            L_SQ: begin
                if (mul_done) begin
                    frac_next  = {frac_reg[frms_pkg::LG_FRAC-2:0], sq[SQR_W-1]};
                    round_next = round_reg - 1'b1;
                    if (round_reg == frms_pkg::RND_W'(1)) begin
                        done_next  = 1'b1;
                        state_next = L_IDLE;
                    end else begin
                        mul_ctl.start = 1'b1;
                        mul_op        = next_m;
                    end
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge aclk) begin
        norm_reg <= norm_next;
        exp_reg  <= exp_next;
        frac_reg <= frac_next;
    end

    assign lg   = {exp_reg, frac_reg};
    assign done = done_reg;

endmodule

// File: rtl/frame_rms_dbfs_meter_core.sv
// Frame RMS level meter, result in dBFS as signed tenths of a dB.
// Input channel (s_valid/s_ready): one signed 16-bit sample per beat, with
// s_last_sample closing the frame. Result channel (m_valid/m_ready): one beat
// per frame with the level, a floor flag for frames whose mean square is
// below one (the level is then the floor register), and a truncated flag
// when samples past MAX_SAMPLES were dropped.
// cfg_we/cfg_wdata write the floor level; write it only while idle.
// Each sample's square comes from a 31-bit bit-serial shift-add multiplier
// run for 16 steps, then is added to the sum. Samples past the limit are
// accepted without a square. A frame end adds the log step: two log2
// evaluations, each a normalising shift of up to LW-1 bit positions plus 16
// squaring rounds through a second serial multiplier, then a scaling
// multiply on the first one. Reset clears the sum, the count, the truncated
// flag and m_valid, and sets the floor to -100.0.
// A stalled receiver holds the result in the output register; the next
// frame's samples keep flowing, and only the following frame end waits.
module frame_rms_dbfs_meter_core #(
    parameter int MAX_SAMPLES = frms_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [frms_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_last_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [frms_pkg::LEVEL_W-1:0]  m_level_tenths,
    output logic                                 m_at_floor,
    output logic                                 m_truncated,
    input  logic                                 cfg_we,
    input  logic signed [frms_pkg::LEVEL_W-1:0]  cfg_wdata
);

    localparam int W       = frms_pkg::MUL_W;
    localparam int LEVEL_W = frms_pkg::LEVEL_W;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = frms_pkg::SQUARE_LOG2 + CNT_W;
    localparam int LW      = (SUM_W > W) ? SUM_W : W;
    localparam int LG_W    = $clog2(LW) + frms_pkg::LG_FRAC;
    localparam logic [LG_W-1:0] FULL_Q =
        LG_W'(frms_pkg::FULL_SCALE_LOG2 * (2 ** frms_pkg::LG_FRAC));

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SQUARE  = 7'b0000010,
        ST_CHECK   = 7'b0000100,
        ST_LOG_SUM = 7'b0001000,
        ST_LOG_CNT = 7'b0010000,
        ST_SCALE   = 7'b0100000,
        ST_OUT     = 7'b1000000
    } state_t;

    state_t                              state_reg, state_next;
    logic [SUM_W-1:0]                    sum_reg, sum_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                ovf_reg, ovf_next;
    logic                                last_reg, last_next;
    logic [LG_W-1:0]                     lg_sum_reg, lg_sum_next;
    logic [LEVEL_W-1:0]                  level_reg, level_next;
    logic                                at_floor_reg, at_floor_next;
    logic signed [LEVEL_W-1:0]           floor_reg;
    logic [LEVEL_W-1:0]                  m_level_reg;
    logic                                m_at_floor_reg;
    logic                                m_trunc_reg;
    logic                                m_valid_reg, m_valid_next;
    logic                                load_out;

    logic [frms_pkg::SAMPLE_W-1:0]       raw;
    logic [frms_pkg::SAMPLE_W-1:0]       mag;
    logic                                accept;

    frms_pkg::mul_ctl_t                  mul_ctl;
    logic [W-1:0]                        mul_a, mul_b;
    logic [2*W-1:0]                      mul_prod;
    logic                                mul_done;
    logic [frms_pkg::SQUARE_W-1:0]       square;
    logic [2*W-1:0]                      scaled;
    logic [LEVEL_W-1:0]                  magnitude;

    logic                                log_start;
    logic [LW-1:0]                       log_x;
    logic [LG_W-1:0]                     log_res;
    logic                                log_done;
    logic [LG_W:0]                       lg_diff;
    logic [LG_W-1:0]                     t_val;

    frms_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_prod),
        .done    (mul_done)
    );

    frms_log2 #(
        .LW (LW)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .x       (log_x),
        .lg      (log_res),
        .done    (log_done)
    );

    // sample magnitude, full-scale negative maps to 2^15
    assign raw    = s_sample;
    assign mag    = raw[frms_pkg::SAMPLE_W-1] ? (frms_pkg::SAMPLE_W'(0) - raw) : raw;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // a 16-step run leaves the square shifted up by the unused steps
    assign square = mul_prod[W - frms_pkg::SAMPLE_W +: frms_pkg::SQUARE_W];

    // level magnitude rounded to nearest, halves upward
    assign scaled    = mul_prod + ((2 * W)'(1) << (frms_pkg::ROUND_SHIFT - 1));
    assign magnitude = scaled[frms_pkg::ROUND_SHIFT +: LEVEL_W];

    // distance below full scale in log2 units, clamped at zero
    assign lg_diff = {1'b0, lg_sum_reg} - {1'b0, log_res};
    assign t_val   = (lg_diff[LG_W] || lg_diff[LG_W-1:0] >= FULL_Q) ?
                     '0 : (FULL_Q - lg_diff[LG_W-1:0]);

    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        lg_sum_next   = lg_sum_reg;
        level_next    = level_reg;
        at_floor_next = at_floor_reg;
        mul_ctl.start = 1'b0;
        mul_ctl.steps = frms_pkg::STEP_W'(frms_pkg::SAMPLE_W);
        mul_a         = W'(mag);
        mul_b         = W'(mag);
        log_start     = 1'b0;
        log_x         = LW'(sum_reg);
        unique case (state_reg)
            // take a sample; past the limit it only marks the frame
            ST_IDLE: begin
                if (accept) begin
                    last_next = s_last_sample;
                    if (cnt_reg < CNT_W'(MAX_SAMPLES)) begin
                        mul_ctl.start = 1'b1;
                        cnt_next      = cnt_reg + 1'b1;
                        state_next    = ST_SQUARE;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_last_sample) begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            // accumulate the square
            ST_SQUARE: begin
                if (mul_done) begin
                    sum_next   = sum_reg + SUM_W'(square);
                    state_next = last_reg ? ST_CHECK : ST_IDLE;
                end
            end
            // mean square below one reports the floor
            ST_CHECK: begin
                if (sum_reg < SUM_W'(cnt_reg) || cnt_reg == '0) begin
                    level_next    = floor_reg;
                    at_floor_next = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    at_floor_next = 1'b0;
                    log_start     = 1'b1;
                    state_next    = ST_LOG_SUM;
                end
            end
            ST_LOG_SUM: begin
                if (log_done) begin
                    lg_sum_next = log_res;
                    log_start   = 1'b1;
                    log_x       = LW'(cnt_reg);
                    state_next  = ST_LOG_CNT;
                end
            end
            // scale log2 distance to tenths of a dB
            ST_LOG_CNT: begin
                if (log_done) begin
                    mul_ctl.start = 1'b1;
                    mul_ctl.steps = frms_pkg::STEP_W'(W);
                    mul_a         = W'(frms_pkg::TENTHS_PER_LOG2_Q16);
                    mul_b         = W'(t_val);
                    state_next    = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (mul_done) begin
                    level_next = LEVEL_W'(0) - magnitude;
                    state_next = ST_OUT;
                end
            end
            // hand the result over and clear for the next frame
            ST_OUT: begin
                if (load_out) begin
                    sum_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    // control and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            floor_reg   <= frms_pkg::FLOOR_RESET;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                floor_reg <= cfg_wdata;
            end
        end
    end

    // working and output payload
    always_ff @(posedge aclk) begin
        last_reg     <= last_next;
        lg_sum_reg   <= lg_sum_next;
        level_reg    <= level_next;
        at_floor_reg <= at_floor_next;
        if (load_out) begin
            m_level_reg    <= level_reg;
            m_at_floor_reg <= at_floor_reg;
            m_trunc_reg    <= ovf_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_level_tenths = m_level_reg;
    assign m_at_floor     = m_at_floor_reg;
    assign m_truncated    = m_trunc_reg;

endmodule

// File: verif/frame_rms_dbfs_meter_core_tb.sv
`timescale 1ns / 1ps

module frame_rms_dbfs_meter_core_tb;
    import frms_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int IDLE_PCT      = 28;
    localparam int SETTLE_CYCLES = 64;
    localparam int TAIL_CYCLES   = 1500;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      at_floor;
        logic                      truncated;
    } frame_level_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       s_last_sample = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [LEVEL_W-1:0]  m_level_tenths;
    logic                       m_at_floor;
    logic                       m_truncated;
    logic                       cfg_we = 1'b0;
    logic signed [LEVEL_W-1:0]  cfg_wdata = '0;

    // predictor state
    logic [63:0]               frame_energy = '0;
    int unsigned               frame_samples = 0;
    logic                      samples_dropped = 1'b0;
    logic signed [LEVEL_W-1:0] floor_tenths = FLOOR_RESET;
    frame_level_t              expected_levels[$];

    bit          no_idle = 1'b0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    frame_rms_dbfs_meter_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level_tenths (m_level_tenths),
        .m_at_floor     (m_at_floor),
        .m_truncated    (m_truncated),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // log2 in q16, fraction bits by repeated squaring of a q1.30 mantissa
    function automatic logic [31:0] log2_q16(input logic [63:0] x);
        int               e;
        logic [63:0]      m;
        logic [LG_FRAC-1:0] frac;
        e = 63;
        while (e > 0 && !x[e]) e--;
        m = (e >= MANT_FRAC) ? (x >> (e - MANT_FRAC)) : (x << (MANT_FRAC - e));
        frac = '0;
        for (int i = 0; i < LG_FRAC; i++) begin
            m = (m * m) >> MANT_FRAC;
            frac = frac << 1;
            if (m >= (64'd1 << (MANT_FRAC + 1))) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (32'(e) << LG_FRAC) | 32'(frac);
    endfunction

    // dbfs in tenths from sum of squares and sample count, magnitude rounded
    function automatic logic signed [LEVEL_W-1:0] level_from_energy(
        input logic [63:0] energy, input logic [63:0] count);
        logic [31:0] diff;
        logic [31:0] full;
        logic [31:0] headroom;
        logic [63:0] prod;
        diff = log2_q16(energy) - log2_q16(count);
        full = 32'(FULL_SCALE_LOG2) << LG_FRAC;
        headroom = (diff >= full) ? 32'd0 : (full - diff);
        prod = 64'(headroom) * 64'(TENTHS_PER_LOG2_Q16) + (64'd1 << (ROUND_SHIFT - 1));
        return LEVEL_W'(32'd0 - 32'(prod >> ROUND_SHIFT));
    endfunction

    // accumulate each accepted sample beat, predict the level at frame end
    always @(posedge aclk) begin : predict
        frame_level_t res;
        logic [31:0]  mag;
        if (aresetn && s_valid && s_ready) begin
            mag = s_sample[SAMPLE_W-1] ? 32'(-int'(s_sample)) : 32'(s_sample);
            if (frame_samples < MAX_SAMPLES_DEF) begin
                frame_energy = frame_energy + 64'(mag) * 64'(mag);
                frame_samples = frame_samples + 1;
            end else begin
                samples_dropped = 1'b1;
            end
            if (s_last_sample) begin
                res.truncated = samples_dropped;
                if (frame_energy < 64'(frame_samples)) begin
                    res.level = floor_tenths;
                    res.at_floor = 1'b1;
                end else begin
                    res.level = level_from_energy(frame_energy, 64'(frame_samples));
                    res.at_floor = 1'b0;
                end
                expected_levels.push_back(res);
                frame_energy = '0;
                frame_samples = 0;
                samples_dropped = 1'b0;
            end
        end
    end

    // compare each result beat with the oldest pending frame
    always @(posedge aclk) begin : compare
        frame_level_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result beat with no frame pending: level %0d floor %0b trunc %0b",
                             m_level_tenths, m_at_floor, m_truncated);
            end else begin
                exp_res = expected_levels.pop_front();
                if (m_level_tenths !== exp_res.level || m_at_floor !== exp_res.at_floor ||
                    m_truncated !== exp_res.truncated) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("level mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 exp_res.level, exp_res.at_floor, exp_res.truncated,
                                 m_level_tenths, m_at_floor, m_truncated);
                end
            end
        end
    end

    // one sample beat, with a random gap before it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_sample <= value;
        s_last_sample <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // wait until every frame result is back and the core has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        // let the predictor take in the beat accepted at this edge first
        @(posedge aclk);
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_floor(input logic signed [LEVEL_W-1:0] value);
        settle();
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        floor_tenths = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(7))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2: v = 16'($urandom_range(8)) - 16'd4;
            3: v = '0;
            4: begin
                v = 16'($urandom);
                v = v >>> $urandom_range(15);
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] random_floor();
        logic signed [LEVEL_W-1:0] v;
        v = LEVEL_W'($urandom_range(1280));
        return -v;
    endfunction

    // silent frame straight after reset reports the reset floor
    task automatic test_reset_floor();
        send_sample(16'sd0, 1'b1);
    endtask

    // full scale, one lsb, mean square exactly one and just below it, mixed values
    task automatic test_level_corners();
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b1);
        send_sample(16'sh0100, 1'b0);
        send_sample(-16'sd256, 1'b0);
        send_sample(16'sh0080, 1'b1);
    endtask

    // floor register at -128.0 and 0.0 dB and other values, then back to the reset value
    task automatic test_floor_settings();
        write_floor(-12'sd1280);
        send_sample(16'sd0, 1'b1);
        write_floor(12'sd0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
        write_floor(-12'sd1);
        send_sample(16'sd0, 1'b1);
        write_floor(random_floor());
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        write_floor(FLOOR_RESET);
        send_sample(16'sd0, 1'b1);
    endtask

    // random frames, mostly short, some near-silent and some at full scale
    task automatic test_random_frames(input int unsigned beats);
        int unsigned sent;
        int unsigned len;
        int unsigned kind;
        logic signed [SAMPLE_W-1:0] v;
        sent = 0;
        while (sent < beats) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
            kind = $urandom_range(9);
            for (int i = 0; i < len; i++) begin
                if (kind < 2)
                    v = ($urandom_range(3) == 0) ? (16'($urandom_range(2)) - 16'd1) : 16'sd0;
                else if (kind == 2)
                    v = 16'sh8000;
                else
                    v = random_sample();
                send_sample(v, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_floor();
        test_level_corners();
        test_floor_settings();

        test_random_frames(140);
        write_floor(random_floor());
        no_idle = 1'b1;
        test_random_frames(140);
        no_idle = 1'b0;
        write_floor(random_floor());
        test_random_frames(140);

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        mismatches += expected_levels.size();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
